// ===== sv/cbq_pkg.sv =====
package cbq_pkg;

  // Field widths fixed by the sample formats.
  localparam int SampleW = 24;
  localparam int DataW   = 32;
  localparam int CoefW   = 32;
  localparam int AccW    = 40;
  localparam int ProdW   = 64;
  localparam int CntW    = 4;

  // Register indexes of the configuration port.
  localparam logic [2:0] RegB0    = 3'd0;
  localparam logic [2:0] RegB1    = 3'd1;
  localparam logic [2:0] RegB2    = 3'd2;
  localparam logic [2:0] RegA1    = 3'd3;
  localparam logic [2:0] RegA2    = 3'd4;
  localparam logic [2:0] RegCount = 3'd5;

  // Shared section coefficients, signed Q6.26.
  typedef struct packed {
    logic signed [CoefW-1:0] b0;
    logic signed [CoefW-1:0] b1;
    logic signed [CoefW-1:0] b2;
    logic signed [CoefW-1:0] a1;
    logic signed [CoefW-1:0] a2;
  } coef_t;

  // Word handed from one section cell to the next.
  typedef struct packed {
    logic signed [DataW-1:0] x;
    logic                    ch;
    logic                    thru;
  } tok_t;

endpackage

// ===== sv/cbq_cell.sv =====
module cbq_cell #(
  parameter int CHANNELS = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cbq_pkg::coef_t  coef_i,
  input  logic            en_i,
  input  logic            clr_i,
  input  logic            in_vld_i,
  input  cbq_pkg::tok_t   in_tok_i,
  output logic            out_vld_o,
  output cbq_pkg::tok_t   out_tok_o
);

  localparam int ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [2:0] StepB0  = 3'd0;
  localparam logic [2:0] StepB1  = 3'd1;
  localparam logic [2:0] StepB2  = 3'd2;
  localparam logic [2:0] StepA1  = 3'd3;
  localparam logic [2:0] StepA2  = 3'd4;
  localparam logic [2:0] StepSum = 3'd5;
  localparam logic [2:0] StepOut = 3'd6;

  localparam logic signed [cbq_pkg::ProdW-1:0] RoundHalf = 64'sd33554432;
  localparam logic signed [cbq_pkg::DataW-1:0] YMax = 32'sh7fff_ffff;
  localparam logic signed [cbq_pkg::DataW-1:0] YMin = 32'sh8000_0000;

  // Per-channel history of this section.
  logic signed [cbq_pkg::DataW-1:0] x1_q [CHANNELS];
  logic signed [cbq_pkg::DataW-1:0] x2_q [CHANNELS];
  logic signed [cbq_pkg::DataW-1:0] y1_q [CHANNELS];
  logic signed [cbq_pkg::DataW-1:0] y2_q [CHANNELS];

  logic                               run_q;
  logic [2:0]                         step_q;
  logic                               pvld_q;
  logic                               sub_q;
  logic                               out_vld_q;
  cbq_pkg::tok_t                      tok_q;
  cbq_pkg::tok_t                      out_tok_q;
  logic signed [cbq_pkg::ProdW-1:0]   prod_q;
  logic signed [cbq_pkg::AccW-1:0]    acc_q;

  logic [ChIdxW-1:0]                  ch_idx;
  logic signed [cbq_pkg::CoefW-1:0]   coef_sel;
  logic signed [cbq_pkg::DataW-1:0]   opnd_sel;
  logic signed [cbq_pkg::ProdW-1:0]   mul_w;
  logic signed [cbq_pkg::ProdW-1:0]   rsum_w;
  logic signed [37:0]                 rnd_w;
  logic signed [cbq_pkg::AccW-1:0]    term_w;
  logic signed [cbq_pkg::DataW-1:0]   y_w;
  logic                               start_w;
  logic                               fin_w;

  assign ch_idx  = ChIdxW'(tok_q.ch);
  assign start_w = in_vld_i && en_i && !in_tok_i.thru;
  assign fin_w   = run_q && (step_q == StepOut);

  // One tap per cycle through the shared multiplier.
  always_comb begin
    unique case (step_q)
      StepB0: begin
        coef_sel = coef_i.b0;
        opnd_sel = tok_q.x;
      end
      StepB1: begin
        coef_sel = coef_i.b1;
        opnd_sel = x1_q[ch_idx];
      end
      StepB2: begin
        coef_sel = coef_i.b2;
        opnd_sel = x2_q[ch_idx];
      end
      StepA1: begin
        coef_sel = coef_i.a1;
        opnd_sel = y1_q[ch_idx];
      end
      StepA2: begin
        coef_sel = coef_i.a2;
        opnd_sel = y2_q[ch_idx];
      end
      default: begin
        coef_sel = '0;
        opnd_sel = '0;
      end
    endcase
  end

  assign mul_w = coef_sel * opnd_sel;

  // Round to nearest with ties upward, then drop the 26 fraction bits.
  assign rsum_w = prod_q + RoundHalf;
  assign rnd_w  = rsum_w[63:26];
  assign term_w = sub_q ? -cbq_pkg::AccW'(rnd_w) : cbq_pkg::AccW'(rnd_w);

  // Saturate the exact sum to 32 bits.
  always_comb begin
    if (acc_q[39:31] == 9'h000 || acc_q[39:31] == 9'h1ff) begin
      y_w = acc_q[31:0];
    end else if (acc_q[39]) begin
      y_w = YMin;
    end else begin
      y_w = YMax;
    end
  end

  // Sequencer of the section.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= 1'b0;
      step_q    <= StepB0;
      pvld_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= 1'b0;
      pvld_q    <= run_q && (step_q <= StepA2);
      if (start_w) begin
        run_q  <= 1'b1;
        step_q <= StepB0;
        pvld_q <= 1'b0;
      end else if (in_vld_i) begin
        out_vld_q <= 1'b1;
      end else if (fin_w) begin
        run_q     <= 1'b0;
        out_vld_q <= 1'b1;
      end else if (run_q) begin
        step_q <= step_q + 3'd1;
      end
    end
  end

  // Product, accumulator and output word.
  always_ff @(posedge clk_i) begin
    prod_q <= mul_w;
    sub_q  <= (step_q == StepA1) || (step_q == StepA2);
    if (start_w) begin
      tok_q <= in_tok_i;
      acc_q <= '0;
    end else if (pvld_q) begin
      acc_q <= acc_q + term_w;
    end
    if (in_vld_i && !start_w) begin
      out_tok_q <= in_tok_i;
    end else if (fin_w) begin
      out_tok_q.x    <= y_w;
      out_tok_q.ch   <= tok_q.ch;
      out_tok_q.thru <= tok_q.thru;
    end
  end

  // History shifts once per processed sample; a stage count write clears it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CHANNELS; i++) begin
        x1_q[i] <= '0;
        x2_q[i] <= '0;
        y1_q[i] <= '0;
        y2_q[i] <= '0;
      end
    end else if (clr_i) begin
      for (int i = 0; i < CHANNELS; i++) begin
        x1_q[i] <= '0;
        x2_q[i] <= '0;
        y1_q[i] <= '0;
        y2_q[i] <= '0;
      end
    end else if (fin_w) begin
      x2_q[ch_idx] <= x1_q[ch_idx];
      x1_q[ch_idx] <= tok_q.x;
      y2_q[ch_idx] <= y1_q[ch_idx];
      y1_q[ch_idx] <= y_w;
    end
  end

  assign out_vld_o = out_vld_q;
  assign out_tok_o = out_tok_q;

endmodule

// ===== sv/cascaded_biquad_filter.sv =====
// Channel  | Direction | Handshake          | Contents
// s_axis   | in        | tvalid / tready    | tdata: sample_in; tuser: channel; tlast: block_end
// m_axis   | out       | tvalid / tready    | tdata: sample_out; tuser: channel_out;
//          |           |                    | tlast: block_end_out
// apb      | in        | psel, penable      | six registers at byte addresses 0x00 to 0x14
//
// One word is in the chain at a time. Each active section works through its
// shared multiplier in steps (five taps, sum, saturate, hand-off); each unused
// section passes the word on through its output register, and the next word can
// be taken in the same cycle as the result turns valid on the output.
// Reset restores the default coefficients, one section and zero history.
// A finished word waits in the output register while the next word is taken;
// a stalled output holds the chain once a second result is done.
module cascaded_biquad_filter #(
  parameter int MAX_STAGES = 8,
  parameter int CHANNELS   = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [23:0] sample_in
  input  logic        s_axis_tuser,   // [0] channel
  input  logic        s_axis_tlast,
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [23:0] sample_out
  output logic        m_axis_tuser,   // [0] channel_out
  output logic        m_axis_tlast,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int StW = $clog2(MAX_STAGES + 1);
  localparam logic [StW-1:0] StMax = StW'(MAX_STAGES);
  localparam logic signed [cbq_pkg::DataW-1:0] OutMax = 32'sd8388607;
  localparam logic signed [cbq_pkg::DataW-1:0] OutMin = -32'sd8388608;

  cbq_pkg::coef_t   coef_q;
  logic [StW-1:0]   stages_q;
  logic             busy_q;
  logic             feed_vld_q;
  cbq_pkg::tok_t    feed_tok_q;
  logic             pend_q;
  logic [23:0]      pend_data_q;
  logic             pend_ch_q;
  logic             last_q;
  logic             m_vld_q;
  logic [23:0]      m_data_q;
  logic             m_ch_q;
  logic             m_last_q;

  logic             cfg_wr;
  logic [2:0]       cfg_idx;
  logic             clr_w;
  logic [StW:0]     cnt_w;
  logic [StW-1:0]   cnt_clamp;
  logic             accept_w;
  logic             load_w;
  logic [23:0]      res_w;

  logic             vld_c [MAX_STAGES+1];
  cbq_pkg::tok_t    tok_c [MAX_STAGES+1];

  // Register writes and reads.
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign clr_w   = cfg_wr && (cfg_idx == cbq_pkg::RegCount);
  assign cnt_w   = (StW + 1)'(pwdata[cbq_pkg::CntW-1:0]);

  always_comb begin
    if (cnt_w == '0) begin
      cnt_clamp = StW'(1);
    end else if (cnt_w > (StW + 1)'(MAX_STAGES)) begin
      cnt_clamp = StMax;
    end else begin
      cnt_clamp = cnt_w[StW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.b0 <= 32'sd67108864;
      coef_q.b1 <= '0;
      coef_q.b2 <= '0;
      coef_q.a1 <= '0;
      coef_q.a2 <= '0;
      stages_q  <= StW'(1);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        cbq_pkg::RegB0:    coef_q.b0 <= pwdata;
        cbq_pkg::RegB1:    coef_q.b1 <= pwdata;
        cbq_pkg::RegB2:    coef_q.b2 <= pwdata;
        cbq_pkg::RegA1:    coef_q.a1 <= pwdata;
        cbq_pkg::RegA2:    coef_q.a2 <= pwdata;
        cbq_pkg::RegCount: stages_q  <= cnt_clamp;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      cbq_pkg::RegB0:    prdata = coef_q.b0;
      cbq_pkg::RegB1:    prdata = coef_q.b1;
      cbq_pkg::RegB2:    prdata = coef_q.b2;
      cbq_pkg::RegA1:    prdata = coef_q.a1;
      cbq_pkg::RegA2:    prdata = coef_q.a2;
      cbq_pkg::RegCount: prdata = 32'(stages_q);
      default:           prdata = '0;
    endcase
  end

  // Input side: one word in the chain at a time.
  assign s_axis_tready = !busy_q;
  assign accept_w      = s_axis_tvalid && !busy_q;

  always_ff @(posedge clk_i) begin
    if (accept_w) begin
      feed_tok_q.x    <= cbq_pkg::DataW'(signed'(s_axis_tdata));
      feed_tok_q.ch   <= s_axis_tuser;
      feed_tok_q.thru <= (32'(s_axis_tuser) >= CHANNELS);
      last_q          <= s_axis_tlast;
    end
  end

  assign vld_c[0] = feed_vld_q;
  assign tok_c[0] = feed_tok_q;

  // Row of section cells.
  for (genvar k = 0; k < MAX_STAGES; k++) begin : g_cell
    localparam logic [StW-1:0] Idx = StW'(k);
    cbq_cell #(
      .CHANNELS (CHANNELS)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .coef_i    (coef_q),
      .en_i      (Idx < stages_q),
      .clr_i     (clr_w),
      .in_vld_i  (vld_c[k]),
      .in_tok_i  (tok_c[k]),
      .out_vld_o (vld_c[k+1]),
      .out_tok_o (tok_c[k+1])
    );
  end

  // Final saturation to 24 bits.
  always_comb begin
    if (tok_c[MAX_STAGES].x > OutMax) begin
      res_w = OutMax[23:0];
    end else if (tok_c[MAX_STAGES].x < OutMin) begin
      res_w = OutMin[23:0];
    end else begin
      res_w = tok_c[MAX_STAGES].x[23:0];
    end
  end

  // Output register, with one pending slot while the output stalls.
  assign load_w = !m_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      feed_vld_q <= 1'b0;
      pend_q     <= 1'b0;
      m_vld_q    <= 1'b0;
    end else begin
      feed_vld_q <= accept_w;
      if (m_vld_q && m_axis_tready) begin
        m_vld_q <= 1'b0;
      end
      if (accept_w) begin
        busy_q <= 1'b1;
      end else if (vld_c[MAX_STAGES]) begin
        if (load_w) begin
          m_vld_q <= 1'b1;
          busy_q  <= 1'b0;
        end else begin
          pend_q <= 1'b1;
        end
      end else if (pend_q && load_w) begin
        m_vld_q <= 1'b1;
        pend_q  <= 1'b0;
        busy_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_c[MAX_STAGES]) begin
      pend_data_q <= res_w;
      pend_ch_q   <= tok_c[MAX_STAGES].ch;
    end
    if (vld_c[MAX_STAGES] && load_w) begin
      m_data_q <= res_w;
      m_ch_q   <= tok_c[MAX_STAGES].ch;
      m_last_q <= last_q;
    end else if (pend_q && load_w) begin
      m_data_q <= pend_data_q;
      m_ch_q   <= pend_ch_q;
      m_last_q <= last_q;
    end
  end

  assign m_axis_tvalid = m_vld_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_ch_q;
  assign m_axis_tlast  = m_last_q;

endmodule
